FILE: hw/rtl/png_row_unfilter_core_macros.svh
// ----------------------------------------------------------------------------
// PNG row unfilter assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PNG_ROW_UNFILTER_CORE_MACROS_SVH
`define PNG_ROW_UNFILTER_CORE_MACROS_SVH

// Same-cycle implication.
`define PRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("png_row_unfilter: assertion failed");

// Next-cycle implication.
`define PRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("png_row_unfilter: assertion failed");

`endif

FILE: hw/rtl/png_ruf_pkg.sv
// ----------------------------------------------------------------------------
// PNG row unfilter package
// Payload types, filter codes and configuration register indexes.
// ----------------------------------------------------------------------------
package png_ruf_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       no_row_above;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_in_row;
    logic       unknown_filter;
  } out_item_t;

  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVG     = 3'd3,
    FILT_PAETH   = 3'd4,
    FILT_UNKNOWN = 3'd5
  } filt_e;

  typedef enum logic [1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_PIXELS_PER_ROW  = 2'd1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned BppW     = 3;
  localparam int unsigned PprW     = 14;

  localparam logic [BppW-1:0] BppReset = 3'd3;
  localparam logic [PprW-1:0] PprReset = 14'd640;

  // Highest filter code with a defined predictor.
  localparam logic [7:0] FiltMaxKnown = 8'd4;

endpackage

FILE: hw/rtl/png_ruf_ram.sv
// ----------------------------------------------------------------------------
// PNG row unfilter RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module png_ruf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/png_ruf_predict.sv
// ----------------------------------------------------------------------------
// PNG row unfilter predictor
// Forms the filter predictor and adds it to the filtered byte modulo 256.
// ----------------------------------------------------------------------------
module png_ruf_predict import png_ruf_pkg::*; (
  input  filt_e      filt_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] left_i,
  input  logic [7:0] up_i,
  input  logic [7:0] upleft_i,
  output logic [7:0] result_o
);

  // Pick whichever neighbor lies closest to left + up - upleft.
  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [10:0] da, db, dc;
    logic        [9:0]  pa, pb, pc;
    logic        [7:0]  res;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = 10'(da < 0 ? -da : da);
    pb = 10'(db < 0 ? -db : db);
    pc = 10'(dc < 0 ? -dc : dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  logic [8:0] avg_sum;
  logic [7:0] pred;

  assign avg_sum = {1'b0, left_i} + {1'b0, up_i};

  always_comb begin
    unique case (filt_i)
      FILT_SUB:   pred = left_i;
      FILT_UP:    pred = up_i;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(left_i, up_i, upleft_i);
      default:    pred = 8'd0;
    endcase
  end

  assign result_o = byte_i + pred;

endmodule

FILE: hw/rtl/png_row_unfilter_core.sv
// ----------------------------------------------------------------------------
// PNG row unfilter core
// Rebuilds raw PNG rows from filtered bytes, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): the byte stream.
//   The first byte of each row is the filter type, sampled together with
//   no_row_above; it yields no output. Every following row byte yields one
//   output transfer on out_valid_o / out_stall_i / out_data_o, with
//   last_in_row set on the final byte of the row.
//   Configuration (cfg_valid_i / cfg_ready_o): index 0 bytes per pixel,
//   index 1 pixels per row. Always ready; write only while no byte is in
//   flight. A new row length applies at once, also mid-row.
//   A data byte passes the predict stage, then the output register.
//   Throughput: one byte per cycle, filter bytes included, unless the
//   output stalls; set by the row store in the same single-port-pair RAM:
//   one read per byte at input transfer, one write as it leaves predict.
//   Reset: a filter byte is expected first, histories are zero, the row
//   above counts as absent. No clearing pass: the row store is undefined
//   until written. A stalled receiver holds the output register, then the
//   predict stage, then the input through in_stall_o.
// ----------------------------------------------------------------------------
`include "png_row_unfilter_core_macros.svh"

module png_row_unfilter_core import png_ruf_pkg::*; #(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte stream in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // reconstructed bytes out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW    = $clog2(MAX_ROW_BYTES);
  localparam int unsigned PosW     = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned HistIdxW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned ProdW    = PprW + 4;

  // Predict-stage contents: one data byte with its row context.
  typedef struct packed {
    logic [7:0]       byte_in;
    filt_e            filt;
    logic             absent;
    logic             last;
    logic [AddrW-1:0] slot;
  } s1_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BppW-1:0] bpp_q;
  logic [PprW-1:0] ppr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BppReset;
      ppr_q <= PprReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BYTES_PER_PIXEL: bpp_q <= cfg_data_i[BppW-1:0];
        CFG_PIXELS_PER_ROW:  ppr_q <= cfg_data_i[PprW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp bytes per pixel to 1..MAX_PIXEL_BYTES and pixels per row to >= 1.
  logic [3:0]          bpp_eff;
  logic [PprW-1:0]     ppr_eff;
  logic [ProdW-1:0]    row_prod;
  logic [PosW-1:0]     row_len;
  logic [HistIdxW-1:0] hist_idx;

  always_comb begin
    priority if (bpp_q == '0) begin
      bpp_eff = 4'd1;
    end else if ({1'b0, bpp_q} > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = {1'b0, bpp_q};
    end
  end

  assign ppr_eff  = (ppr_q == '0) ? PprW'(1) : ppr_q;
  assign row_prod = ProdW'(ppr_eff) * ProdW'(bpp_eff);
  assign row_len  = (row_prod > ProdW'(MAX_ROW_BYTES)) ? PosW'(MAX_ROW_BYTES)
                                                      : PosW'(row_prod);
  assign hist_idx = HistIdxW'(bpp_eff - 4'd1);

  // --------------------------------------------------------------------------
  // Front end: row position and row context, updated at input transfer
  // --------------------------------------------------------------------------
  logic            in_xfer;
  logic            is_filt_byte;
  logic            data_xfer;
  logic            row_last;
  logic [PosW-1:0] pos_q;
  filt_e           filt_q;
  logic            absent_q;
  logic [AddrW-1:0] slot;

  logic  s1_valid_q;
  s1_t   s1_q;
  logic  s1_fire;
  logic  out_valid_q;
  out_item_t out_q;

  assign in_xfer      = in_valid_i && !in_stall_o;
  assign is_filt_byte = (pos_q == '0);
  assign data_xfer    = in_xfer && !is_filt_byte;
  assign row_last     = (pos_q >= row_len);
  assign slot         = AddrW'(pos_q - PosW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      filt_q   <= FILT_NONE;
      absent_q <= 1'b1;
    end else if (in_xfer) begin
      if (is_filt_byte) begin
        // Latch the row's filter; every code above Paeth maps to unknown.
        filt_q   <= (in_data_i.byte_in > FiltMaxKnown) ? FILT_UNKNOWN
                                                       : filt_e'(in_data_i.byte_in[2:0]);
        absent_q <= in_data_i.no_row_above;
        pos_q    <= PosW'(1);
      end else begin
        // Advance, or wrap to expect the next filter byte.
        pos_q <= row_last ? '0 : pos_q + PosW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row store: read the row above at input transfer, write back as predict moves on
  // --------------------------------------------------------------------------
  logic [7:0] ram_rdata;
  logic [7:0] result;

  // A slot is written back before the next row can read it: a filter byte
  // always lies between, and it transfers only once the predict stage moves.
  png_ruf_ram #(
    .Width (8),
    .Depth (MAX_ROW_BYTES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.slot),
    .wdata_i (result),
    .re_i    (data_xfer),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Predict stage
  // --------------------------------------------------------------------------
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  // Hold the input while the predict stage is full and cannot move on.
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (data_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_xfer) begin
      s1_q.byte_in <= in_data_i.byte_in;
      s1_q.filt    <= filt_q;
      s1_q.absent  <= absent_q;
      s1_q.last    <= row_last;
      s1_q.slot    <= slot;
    end
  end

  logic [7:0] left_q   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_q [MAX_PIXEL_BYTES];
  logic [7:0] up_byte;

  assign up_byte = s1_q.absent ? 8'd0 : ram_rdata;

  png_ruf_predict u_predict (
    .filt_i   (s1_q.filt),
    .byte_i   (s1_q.byte_in),
    .left_i   (left_q[hist_idx]),
    .up_i     (up_byte),
    .upleft_i (upleft_q[hist_idx]),
    .result_o (result)
  );

  // Pixel history: shift in each finished byte; a filter byte clears it.
  // The clear wins over a shift from the previous row's last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else if (in_xfer && is_filt_byte) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else if (s1_fire) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_q[k]   <= left_q[k-1];
        upleft_q[k] <= upleft_q[k-1];
      end
      left_q[0]   <= result;
      upleft_q[0] <= up_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q.byte_out       <= result;
      out_q.last_in_row    <= s1_q.last;
      out_q.unknown_filter <= (s1_q.filt == FILT_UNKNOWN);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PRU_ASSERT_NEXT(a_filt_byte_empties_s1, in_xfer && is_filt_byte, !s1_valid_q)
  `PRU_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q <= PosW'(MAX_ROW_BYTES))
  `PRU_ASSERT_NEXT(a_last_reaches_out, s1_fire && s1_q.last,
                   out_valid_q && out_q.last_in_row)
  `PRU_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_q && out_valid_q && out_stall_i,
                   s1_valid_q && $stable(s1_q))

endmodule
